[hw/rtl/dvsec_register_shadow_macros.svh]
`ifndef DVSEC_REGISTER_SHADOW_MACROS_SVH
`define DVSEC_REGISTER_SHADOW_MACROS_SVH

// Same-cycle implication, sampled on clk, off during reset.
`define DVS_ASSERT_NOW(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Implication checked in the next cycle.
`define DVS_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

[hw/rtl/dvs_pkg.sv]
package dvs_pkg;

	localparam int MAX_LEN      = 64;
	localparam int BODY_START   = 10;
	localparam int SHADOW_BYTES = ((MAX_LEN - BODY_START + 3) / 4) * 4;
	localparam int ROWS         = SHADOW_BYTES / 4;
	localparam int BANK_DEPTH   = (ROWS + 1) / 2;
	localparam int ROW_W        = $clog2(ROWS);
	localparam int BANK_AW      = $clog2(BANK_DEPTH);

	localparam logic [6:0] LEN_RESET = 7'd56;
	localparam logic [6:0] LEN_MAX   = 7'(MAX_LEN);

	localparam logic [5:0] OFF_BODY    = 6'h0a;
	localparam logic [5:0] OFF_CTRL    = 6'h0c;
	localparam logic [5:0] OFF_STATUS  = 6'h0e;
	localparam logic [5:0] OFF_CTRL2   = 6'h10;
	localparam logic [5:0] OFF_STATUS2 = 6'h12;
	localparam logic [5:0] OFF_LOCK    = 6'h14;
	localparam logic [5:0] OFF_WIDE    = 6'h18;
	localparam logic [15:0] LOCK_BIT   = 16'h0001;

	// APB: one 32-bit register at byte address 0
	localparam int CFG_ADDR_W = 3;
	localparam logic [CFG_ADDR_W-3:0] REG_DVSEC_LENGTH = '0;

	typedef enum logic [1:0] {
		REQ_READ    = 2'd0,
		REQ_WRITE   = 2'd1,
		REQ_PRELOAD = 2'd2,
		REQ_RSVD    = 2'd3
	} req_t;

	typedef enum logic [1:0] {
		FLD_NONE   = 2'd0,
		FLD_CTRL   = 2'd1,
		FLD_STATUS = 2'd2,
		FLD_LOCK   = 2'd3
	} field_t;

	typedef struct packed {
		logic             rejected;
		logic [ROW_W-1:0] row;
		logic [1:0]       lane;
		logic [3:0]       byte_mask;
		field_t           field;
	} acc_t;

endpackage

[hw/rtl/dvs_ifs.sv]
interface dvs_req_if;
	logic        valid;
	logic        ready;
	logic [1:0]  req_type;
	logic [5:0]  offset;
	logic [2:0]  size;
	logic [31:0] write_data;

	modport source (output valid, req_type, offset, size, write_data, input ready);
	modport sink (input valid, req_type, offset, size, write_data, output ready);
endinterface

interface dvs_rsp_if;
	logic        valid;
	logic        ready;
	logic [31:0] read_data;
	logic        rejected;
	logic        config_locked;

	modport source (output valid, read_data, rejected, config_locked, input ready);
	modport sink (input valid, read_data, rejected, config_locked, output ready);
endinterface

[hw/rtl/dvs_access_decode.sv]
module dvs_access_decode import dvs_pkg::*; (
	input  logic [1:0] req_type,
	input  logic [5:0] offset,
	input  logic [2:0] size,
	input  logic [6:0] dvsec_length,
	output acc_t       acc
);

	logic [6:0] len_eff;
	logic [6:0] end_off;
	logic [5:0] idx;
	logic [5:0] base;
	logic       size_ok;

	assign len_eff = (dvsec_length > LEN_MAX) ? LEN_MAX : dvsec_length;
	assign end_off = {1'b0, offset} + {4'b0, size};
	assign idx     = offset - OFF_BODY;
	assign base    = {offset[5:1], 1'b0};

	always_comb begin
		unique case (size)
			3'd1: acc.byte_mask = 4'b0001;
			3'd2: acc.byte_mask = 4'b0011;
			3'd4: acc.byte_mask = 4'b1111;
			default: acc.byte_mask = 4'b0000;
		endcase
	end

	assign size_ok = (acc.byte_mask != 4'b0000);

	assign acc.rejected = !size_ok || (offset < OFF_BODY) || (end_off > len_eff) ||
		(req_t'(req_type) == REQ_RSVD);
	assign acc.row  = idx[5:2];
	assign acc.lane = idx[1:0];

	// 16-bit fields live below 0x18; everything from there on drops guest writes
	always_comb begin
		acc.field = FLD_NONE;
		if (offset < OFF_WIDE) begin
			unique case (base) inside
				OFF_CTRL, OFF_CTRL2:     acc.field = FLD_CTRL;
				OFF_STATUS, OFF_STATUS2: acc.field = FLD_STATUS;
				OFF_LOCK:                acc.field = FLD_LOCK;
				default:                 acc.field = FLD_NONE;
			endcase
		end
	end

endmodule

[hw/rtl/dvs_field_merge.sv]
module dvs_field_merge import dvs_pkg::*; (
	input  acc_t        acc,
	input  logic [1:0]  req_type,
	input  logic [31:0] write_data,
	input  logic [63:0] rd_window,
	input  logic        locked,
	output logic [31:0] read_data,
	output logic [7:0]  wr_en,
	output logic [63:0] wr_data,
	output logic        lock_set
);

	logic [31:0] lane_bits;
	logic [63:0] shifted;
	logic [15:0] cur;
	logic [31:0] data_l;
	logic [31:0] wbits32;
	logic [31:0] lmask32;
	logic [15:0] wbits;
	logic [15:0] merged;
	logic [15:0] field_new;
	logic        field_we;
	logic        lock_hit;
	logic [7:0]  field_en;

	assign lane_bits = {{8{acc.byte_mask[3]}}, {8{acc.byte_mask[2]}},
		{8{acc.byte_mask[1]}}, {8{acc.byte_mask[0]}}};
	assign shifted   = rd_window >> {acc.lane, 3'b000};

	// field is 16 bits at lane 0 or 2 of the access row; lane[0] picks the high byte
	assign cur     = acc.lane[1] ? rd_window[31:16] : rd_window[15:0];
	assign data_l  = write_data & lane_bits;
	assign wbits32 = acc.lane[0] ? (data_l << 8) : data_l;
	assign lmask32 = acc.lane[0] ? (lane_bits << 8) : lane_bits;
	assign wbits   = wbits32[15:0];
	assign merged  = (cur & ~lmask32[15:0]) | wbits;
	assign field_en = acc.lane[1] ? 8'b0000_1100 : 8'b0000_0011;

	always_comb begin
		field_new = cur;
		field_we  = 1'b0;
		lock_hit  = 1'b0;
		case (acc.field)
			FLD_CTRL: begin
				field_new = merged;
				field_we  = !locked;
			end
			FLD_STATUS: begin
				field_new = cur & ~wbits;
				field_we  = 1'b1;
			end
			FLD_LOCK: begin
				field_new = cur | LOCK_BIT;
				field_we  = ((cur & LOCK_BIT) == '0) && ((merged & LOCK_BIT) != '0);
				lock_hit  = field_we;
			end
			default: begin
				field_we = 1'b0;
			end
		endcase
	end

	// only an accepted guest write can raise the lock
	always_comb begin
		read_data = '0;
		wr_en     = '0;
		wr_data   = '0;
		lock_set  = 1'b0;
		if (!acc.rejected) begin
			unique case (req_t'(req_type))
				REQ_READ: begin
					read_data = shifted[31:0] & lane_bits;
				end
				REQ_PRELOAD: begin
					wr_en   = {4'b0000, acc.byte_mask} << acc.lane;
					wr_data = {32'b0, write_data} << {acc.lane, 3'b000};
				end
				REQ_WRITE: begin
					wr_en    = field_we ? field_en : 8'b0;
					wr_data  = {32'b0, field_new, field_new};
					lock_set = lock_hit;
				end
				default: begin
					wr_en = '0;
				end
			endcase
		end
	end

endmodule

[hw/rtl/dvs_shadow_store.sv]
module dvs_shadow_store import dvs_pkg::*; (
	input  logic             clk,
	input  logic             arst_n,
	input  logic [ROW_W-1:0] row,
	input  logic [7:0]       wr_en,
	input  logic [63:0]      wr_data,
	output logic [63:0]      rd_window
);

	// rows alternate between two banks so a window of two rows reads one address per bank
	logic [31:0]        even_q [BANK_DEPTH];
	logic [31:0]        odd_q  [BANK_DEPTH];
	logic [BANK_AW-1:0] even_addr;
	logic [BANK_AW-1:0] odd_addr;
	logic               even_ok;
	logic               odd_ok;
	logic [31:0]        rd_even;
	logic [31:0]        rd_odd;
	logic [3:0]         even_en;
	logic [3:0]         odd_en;
	logic [31:0]        even_wd;
	logic [31:0]        odd_wd;

	assign even_addr = BANK_AW'(row[ROW_W-1:1]) + BANK_AW'(row[0]);
	assign odd_addr  = BANK_AW'(row[ROW_W-1:1]);
	assign even_ok   = even_addr < BANK_AW'(BANK_DEPTH);
	assign odd_ok    = odd_addr < BANK_AW'(BANK_DEPTH);
	assign rd_even   = even_ok ? even_q[even_addr] : '0;
	assign rd_odd    = odd_ok ? odd_q[odd_addr] : '0;
	assign rd_window = row[0] ? {rd_even, rd_odd} : {rd_odd, rd_even};

	assign even_en = row[0] ? wr_en[7:4] : wr_en[3:0];
	assign odd_en  = row[0] ? wr_en[3:0] : wr_en[7:4];
	assign even_wd = row[0] ? wr_data[63:32] : wr_data[31:0];
	assign odd_wd  = row[0] ? wr_data[31:0] : wr_data[63:32];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < BANK_DEPTH; i++) begin
				even_q[i] <= '0;
				odd_q[i]  <= '0;
			end
		end else begin
			for (int b = 0; b < 4; b++) begin
				if (even_en[b] && even_ok) begin
					even_q[even_addr][8*b +: 8] <= even_wd[8*b +: 8];
				end
				if (odd_en[b] && odd_ok) begin
					odd_q[odd_addr][8*b +: 8] <= odd_wd[8*b +: 8];
				end
			end
		end
	end

endmodule

[hw/rtl/dvsec_register_shadow.sv]
// DVSEC body register shadow.
// req channel: one access per item (read, guest write or raw preload of 1, 2
// or 4 bytes at a byte offset of the capability). rsp channel: exactly one
// item per request, in order, with read data, a reject flag and the lock state.
// An item is taken into an input register, then decoded and applied as it
// moves into the result register that drives rsp.valid. One item per cycle
// is sustained while rsp is not stalled. The rate is set by the shadow row's
// read-modify-write, which completes as the item enters the result register.
// A stalled rsp keeps its item; one more request is still taken into the input
// register, after which req.ready drops until rsp drains.
// APB: dvsec_length at byte address 0; the user must write it only while no
// item is in flight, the block does not check it. Reset zeroes the shadow, the
// lock latch and both valid flags and sets dvsec_length to 56; ready right after.
module dvsec_register_shadow import dvs_pkg::*; (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  psel,
	input  logic                  penable,
	input  logic                  pwrite,
	input  logic [CFG_ADDR_W-1:0] paddr,
	input  logic [31:0]           pwdata,
	output logic [31:0]           prdata,
	output logic                  pready,
	dvs_req_if.sink               req,
	dvs_rsp_if.source             rsp
);

	`include "dvsec_register_shadow_macros.svh"

	logic [6:0]  len_q;
	logic        lock_q;

	logic        s1_valid_q;
	logic [1:0]  req_type_s1;
	logic [5:0]  offset_s1;
	logic [2:0]  size_s1;
	logic [31:0] wdata_s1;

	logic        rsp_valid_q;
	logic [31:0] read_data_q;
	logic        rejected_q;
	logic        locked_q;

	logic        advance;
	logic        accept;
	logic        cfg_wr;
	acc_t        acc;
	logic [63:0] rd_window;
	logic [31:0] read_data;
	logic [7:0]  wr_en;
	logic [63:0] wr_data;
	logic        lock_set;

	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite && pready &&
		(paddr[CFG_ADDR_W-1:2] == REG_DVSEC_LENGTH);
	assign prdata = (paddr[CFG_ADDR_W-1:2] == REG_DVSEC_LENGTH) ? {25'b0, len_q} : '0;

	assign advance   = s1_valid_q && (!rsp_valid_q || rsp.ready);
	assign req.ready = !s1_valid_q || advance;
	assign accept    = req.valid && req.ready;

	dvs_access_decode u_decode (
		.req_type     (req_type_s1),
		.offset       (offset_s1),
		.size         (size_s1),
		.dvsec_length (len_q),
		.acc          (acc)
	);

	dvs_shadow_store u_store (
		.clk       (clk),
		.arst_n    (arst_n),
		.row       (acc.row),
		.wr_en     (advance ? wr_en : 8'b0),
		.wr_data   (wr_data),
		.rd_window (rd_window)
	);

	dvs_field_merge u_merge (
		.acc        (acc),
		.req_type   (req_type_s1),
		.write_data (wdata_s1),
		.rd_window  (rd_window),
		.locked     (lock_q),
		.read_data  (read_data),
		.wr_en      (wr_en),
		.wr_data    (wr_data),
		.lock_set   (lock_set)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			len_q       <= LEN_RESET;
			lock_q      <= 1'b0;
			s1_valid_q  <= 1'b0;
			rsp_valid_q <= 1'b0;
		end else begin
			if (cfg_wr) begin
				len_q <= pwdata[6:0];
			end
			if (advance && lock_set) begin
				lock_q <= 1'b1;
			end
			if (req.ready) begin
				s1_valid_q <= req.valid;
			end
			if (advance) begin
				rsp_valid_q <= 1'b1;
			end else if (rsp.ready) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			req_type_s1 <= req.req_type;
			offset_s1   <= req.offset;
			size_s1     <= req.size;
			wdata_s1    <= req.write_data;
		end
		if (advance) begin
			read_data_q <= read_data;
			rejected_q  <= acc.rejected;
			locked_q    <= lock_q || lock_set;
		end
	end

	assign rsp.valid         = rsp_valid_q;
	assign rsp.read_data     = read_data_q;
	assign rsp.rejected      = rejected_q;
	assign rsp.config_locked = locked_q;

	`DVS_ASSERT_NEXT(a_lock_sticky, lock_q, lock_q, "lock latch dropped")
	`DVS_ASSERT_NOW(a_rej_no_write, s1_valid_q && acc.rejected, wr_en == 8'b0,
		"rejected access writes the shadow")
	`DVS_ASSERT_NOW(a_rej_zero_data, rsp.valid && rsp.rejected, rsp.read_data == 32'b0,
		"rejected item returns data")
	`DVS_ASSERT_NEXT(a_locked_out, advance, rsp.config_locked == lock_q,
		"reported lock differs from latch")

endmodule

[bench/tb_dvsec_register_shadow.sv]
module tb_dvsec_register_shadow import dvs_pkg::*;;

	timeunit 1ns;
	timeprecision 1ps;

	localparam int OFF_BODY_END = 'h38;
	localparam int CYCLE_LIMIT  = 200000;

	typedef struct packed {
		req_t        kind;
		logic [5:0]  offset;
		logic [2:0]  size;
		logic [31:0] data;
	} access_t;

	typedef struct packed {
		logic [31:0] read_data;
		logic        rejected;
		logic        locked;
	} reply_t;

	logic                  clk;
	logic                  arst_n;
	logic                  psel;
	logic                  penable;
	logic                  pwrite;
	logic [CFG_ADDR_W-1:0] paddr;
	logic [31:0]           pwdata;
	logic [31:0]           prdata;
	logic                  pready;

	dvs_req_if req_if ();
	dvs_rsp_if rsp_if ();

	dvsec_register_shadow uut (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.req     (req_if),
		.rsp     (rsp_if)
	);

	// shadow copy kept by the bench
	logic [7:0] shadow [SHADOW_BYTES];
	logic       lock_set;
	logic [6:0] body_len;

	reply_t pending_replies [$];
	int     mismatch_count;
	int     cycle_count;
	int     send_idle_pct;
	int     recv_stall_pct;

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("simulation failed");
			$finish;
		end
	end

	always @(posedge clk)
		rsp_if.ready <= ($urandom_range(99) >= recv_stall_pct);

	function automatic logic [31:0] peek(int base, int n);
		logic [31:0] v;
		int idx;
		v = '0;
		for (int i = 0; i < n; i++) begin
			idx = base - BODY_START + i;
			if (idx >= 0 && idx < SHADOW_BYTES)
				v[8*i +: 8] = shadow[idx];
		end
		return v;
	endfunction

	function automatic void poke(int base, int n, logic [31:0] v);
		int idx;
		for (int i = 0; i < n; i++) begin
			idx = base - BODY_START + i;
			if (idx >= 0 && idx < SHADOW_BYTES)
				shadow[idx] = v[8*i +: 8];
		end
	endfunction

	// guest write: merge into the field holding the first byte, then apply its rule
	function automatic void guest_merge(int off, int sz, logic [31:0] data);
		int base;
		int fwidth;
		int shift;
		logic [31:0] fmask;
		logic [31:0] lanes;
		logic [31:0] cur;
		logic [31:0] wbits;
		logic [31:0] merged;
		if (off < OFF_WIDE) begin
			base = off & ~1;
			fwidth = 2;
			fmask = 32'h0000_ffff;
		end else if (off < OFF_BODY_END) begin
			base = off & ~3;
			fwidth = 4;
			fmask = 32'hffff_ffff;
		end else begin
			return;
		end
		lanes = (sz == 4) ? 32'hffff_ffff : ((sz == 2) ? 32'h0000_ffff : 32'h0000_00ff);
		shift = (off - base) * 8;
		cur = peek(base, fwidth);
		wbits = ((data & lanes) << shift) & fmask;
		merged = ((cur & ~(lanes << shift)) | wbits) & fmask;
		case (base)
			OFF_CTRL, OFF_CTRL2: begin
				if (!lock_set)
					poke(base, 2, merged);
			end
			OFF_STATUS, OFF_STATUS2: begin
				poke(base, 2, cur & ~wbits);
			end
			OFF_LOCK: begin
				if ((cur & LOCK_BIT) == 0 && (merged & LOCK_BIT) != 0) begin
					poke(base, 2, cur | LOCK_BIT);
					lock_set = 1'b1;
				end
			end
			default: ;
		endcase
	endfunction

	function automatic reply_t apply_access(access_t a);
		reply_t r;
		int off;
		int sz;
		int len;
		r = '0;
		off = a.offset;
		sz = a.size;
		len = (body_len > MAX_LEN) ? MAX_LEN : body_len;
		if ((sz != 1 && sz != 2 && sz != 4) || off < BODY_START || off + sz > len ||
				a.kind == REQ_RSVD) begin
			r.rejected = 1'b1;
		end else if (a.kind == REQ_READ) begin
			r.read_data = peek(off, sz);
		end else if (a.kind == REQ_PRELOAD) begin
			poke(off, sz, a.data);
		end else begin
			guest_merge(off, sz, a.data);
		end
		r.locked = lock_set;
		return r;
	endfunction

	always @(posedge clk) begin
		reply_t got;
		reply_t want;
		if (arst_n && rsp_if.valid && rsp_if.ready) begin
			got = '{rsp_if.read_data, rsp_if.rejected, rsp_if.config_locked};
			if (pending_replies.size() == 0) begin
				$display("%0t: reply with none expected: read_data %08h rejected %0b locked %0b",
					$time, got.read_data, got.rejected, got.locked);
				mismatch_count++;
			end else begin
				want = pending_replies.pop_front();
				if (got.read_data !== want.read_data) begin
					$display("%0t: read_data expected %08h actual %08h",
						$time, want.read_data, got.read_data);
					mismatch_count++;
				end
				if (got.rejected !== want.rejected) begin
					$display("%0t: rejected expected %0b actual %0b",
						$time, want.rejected, got.rejected);
					mismatch_count++;
				end
				if (got.locked !== want.locked) begin
					$display("%0t: config_locked expected %0b actual %0b",
						$time, want.locked, got.locked);
					mismatch_count++;
				end
			end
		end
	end

	task automatic send_access(req_t kind, logic [5:0] off, logic [2:0] sz, logic [31:0] data);
		access_t a;
		a = '{kind, off, sz, data};
		while ($urandom_range(99) < send_idle_pct) begin
			req_if.valid <= 1'b0;
			@(posedge clk);
		end
		req_if.valid      <= 1'b1;
		req_if.req_type   <= kind;
		req_if.offset     <= off;
		req_if.size       <= sz;
		req_if.write_data <= data;
		do @(posedge clk); while (!req_if.ready);
		pending_replies.push_back(apply_access(a));
	endtask

	task automatic wait_idle();
		req_if.valid <= 1'b0;
		while (pending_replies.size() != 0)
			@(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic set_body_len(logic [6:0] v);
		wait_idle();
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= {REG_DVSEC_LENGTH, 2'b00};
		pwdata  <= 32'(v);
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		body_len = v;
		// read back
		penable <= 1'b0;
		pwrite  <= 1'b0;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		if (prdata !== 32'(v)) begin
			$display("%0t: dvsec_length readback expected %08h actual %08h",
				$time, 32'(v), prdata);
			mismatch_count++;
		end
		psel    <= 1'b0;
		penable <= 1'b0;
		@(posedge clk);
	endtask

	function automatic access_t random_access(bit hold_lock);
		access_t a;
		int len;
		int sz;
		int pick;
		len = (body_len > MAX_LEN) ? MAX_LEN : body_len;
		if ($urandom_range(99) < 12) begin
			a.kind   = req_t'($urandom_range(3));
			a.offset = 6'($urandom);
			a.size   = 3'($urandom);
			a.data   = $urandom;
		end else begin
			pick = $urandom_range(2);
			sz = (pick == 0) ? 1 : ((pick == 1) ? 2 : 4);
			a.kind = req_t'($urandom_range(2));
			a.size = 3'(sz);
			// favor the narrow control/status fields
			if ($urandom_range(99) < 60)
				a.offset = 6'($urandom_range(OFF_WIDE - 1, OFF_BODY));
			else
				a.offset = 6'($urandom_range(len - sz, OFF_BODY));
			a.data = $urandom;
		end
		// keep the latch down so control writes stay live
		if (hold_lock && a.kind == REQ_WRITE && a.offset == OFF_LOCK)
			a.data[0] = 1'b0;
		return a;
	endfunction

	task automatic test_rejects();
		send_access(REQ_READ,    6'h0a, 3'd4, 32'h0);
		send_access(REQ_READ,    6'h00, 3'd1, 32'h0);
		send_access(REQ_READ,    6'h09, 3'd2, 32'h0);
		send_access(REQ_PRELOAD, 6'h0c, 3'd0, 32'hffff_ffff);
		send_access(REQ_WRITE,   6'h0c, 3'd7, 32'hffff_ffff);
		send_access(REQ_WRITE,   6'h0c, 3'd3, 32'hffff_ffff);
		send_access(REQ_RSVD,    6'h0c, 3'd2, 32'hffff_ffff);
		send_access(REQ_READ,    6'h36, 3'd2, 32'h0);
		send_access(REQ_READ,    6'h3f, 3'd1, 32'h0);
	endtask

	task automatic test_field_rules();
		send_access(REQ_PRELOAD, 6'h0a, 3'd4, 32'hffff_ffff);
		send_access(REQ_PRELOAD, 6'h0e, 3'd4, 32'hffff_ffff);
		send_access(REQ_PRELOAD, 6'h12, 3'd4, 32'hfffe_ffff);
		send_access(REQ_WRITE,   6'h0a, 3'd2, 32'h0);
		// spill into status must be dropped
		send_access(REQ_WRITE,   6'h0c, 3'd4, 32'h0000_1234);
		send_access(REQ_WRITE,   6'h0f, 3'd2, 32'h0000_0081);
		send_access(REQ_WRITE,   6'h12, 3'd1, 32'h0000_000f);
		send_access(REQ_WRITE,   6'h11, 3'd1, 32'h0000_00a5);
		send_access(REQ_WRITE,   6'h16, 3'd2, 32'hffff_ffff);
		send_access(REQ_PRELOAD, 6'h30, 3'd4, 32'h5a5a_5a5a);
		send_access(REQ_WRITE,   6'h30, 3'd4, 32'h0);
		send_access(REQ_READ,    6'h0a, 3'd4, 32'h0);
		send_access(REQ_READ,    6'h0e, 3'd4, 32'h0);
		send_access(REQ_READ,    6'h12, 3'd4, 32'h0);
		send_access(REQ_READ,    6'h30, 3'd4, 32'h0);
	endtask

	task automatic test_lengths();
		set_body_len(LEN_MAX);
		send_access(REQ_WRITE, 6'h38, 3'd4, 32'hffff_ffff);
		send_access(REQ_READ,  6'h3c, 3'd4, 32'h0);
		send_access(REQ_READ,  6'h3d, 3'd4, 32'h0);
		// above the maximum acts as the maximum
		set_body_len(7'd127);
		send_access(REQ_READ,  6'h3c, 3'd4, 32'h0);
		set_body_len(7'd60);
		send_access(REQ_READ,  6'h38, 3'd4, 32'h0);
		send_access(REQ_READ,  6'h39, 3'd4, 32'h0);
	endtask

	task automatic test_lock_latch();
		send_access(REQ_PRELOAD, 6'h14, 3'd2, 32'h0000_0001);
		send_access(REQ_WRITE,   6'h14, 3'd1, 32'h0000_0001);
		send_access(REQ_PRELOAD, 6'h14, 3'd2, 32'h0000_ff00);
		send_access(REQ_WRITE,   6'h15, 3'd1, 32'h0000_00ff);
		send_access(REQ_WRITE,   6'h14, 3'd4, 32'hffff_ffff);
		send_access(REQ_WRITE,   6'h0c, 3'd2, 32'h0000_beef);
		send_access(REQ_PRELOAD, 6'h14, 3'd2, 32'h0);
		send_access(REQ_READ,    6'h0c, 3'd4, 32'h0);
	endtask

	task automatic test_random_traffic(int send_pct, int recv_pct, logic [6:0] len,
			int count, bit hold_lock);
		access_t a;
		set_body_len(len);
		send_idle_pct = send_pct;
		recv_stall_pct = recv_pct;
		repeat (count) begin
			a = random_access(hold_lock);
			send_access(a.kind, a.offset, a.size, a.data);
		end
	endtask

	initial begin
		arst_n  = 1'b0;
		psel    = 1'b0;
		penable = 1'b0;
		pwrite  = 1'b0;
		paddr   = '0;
		pwdata  = '0;
		req_if.valid      = 1'b0;
		req_if.req_type   = REQ_READ;
		req_if.offset     = '0;
		req_if.size       = '0;
		req_if.write_data = '0;
		rsp_if.ready      = 1'b0;
		for (int i = 0; i < SHADOW_BYTES; i++)
			shadow[i] = 8'h00;
		lock_set = 1'b0;
		body_len = LEN_RESET;
		mismatch_count = 0;
		cycle_count = 0;
		send_idle_pct = 0;
		recv_stall_pct = 0;

		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_rejects();
		test_field_rules();
		test_lengths();
		test_random_traffic(0, 0, LEN_RESET, 185, 1'b1);
		test_random_traffic(61, 0, LEN_MAX, 185, 1'b1);
		test_random_traffic(0, 61, 7'($urandom_range(63, 57)), 185, 1'b1);
		test_lock_latch();
		test_random_traffic(7, 7, 7'd127, 190, 1'b0);

		req_if.valid <= 1'b0;
		while (pending_replies.size() != 0)
			@(posedge clk);
		repeat (8) @(posedge clk);
		if (mismatch_count == 0) begin
			$display("simulation ok");
		end else begin
			$display("simulation failed");
		end
		$finish;
	end

endmodule

[files.f]
+incdir+hw/rtl
hw/rtl/dvs_pkg.sv
hw/rtl/dvs_ifs.sv
hw/rtl/dvs_access_decode.sv
hw/rtl/dvs_field_merge.sv
hw/rtl/dvs_shadow_store.sv
hw/rtl/dvsec_register_shadow.sv
bench/tb_dvsec_register_shadow.sv
